// ----- src/smcbt_pkg.sv -----
// ----------------------------------------------------------------------------
// smcbt_pkg
// Shared types and constants for the SPI-mode card block transfer sequencer.
// ----------------------------------------------------------------------------
package smcbt_pkg;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_CARD  = 2'd1,
		KIND_WDATA = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ACT_XCHG  = 2'd0,
		ACT_RDATA = 2'd1,
		ACT_WNEED = 2'd2,
		ACT_DONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_REJECT  = 2'd1,
		ST_TIMEOUT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_READ_POLL  = 2'd0,
		CFG_WRITE_POLL = 2'd1,
		CFG_TOKEN_WAIT = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_FILL, PH_READY, PH_CMD, PH_R1, PH_TOKEN, PH_RDATA, PH_RCRC,
		PH_TRAIL, PH_WTOKEN, PH_WNEED, PH_WDATA, PH_WCRC, PH_WRESP
	} phase_t;

	localparam logic [7:0] BYTE_FF     = 8'hFF;
	localparam logic [7:0] TOKEN_START = 8'hFE;
	localparam logic [7:0] CMD_BASE    = 8'h40;
	localparam logic [7:0] CMD_READ    = 8'd17;
	localparam logic [7:0] CMD_WRITE   = 8'd24;
	localparam logic [7:0] CMD_CRC     = 8'h95;
	localparam logic [2:0] RESP_OK     = 3'd2;
	localparam logic [15:0] READ_POLL_RST  = 16'd1024;
	localparam logic [15:0] WRITE_POLL_RST = 16'd8092;
	localparam logic [15:0] TOKEN_WAIT_RST = 16'd65535;

	typedef struct packed {
		logic [1:0]  kind;
		logic        is_write;
		logic [22:0] sector;
		logic [7:0]  byte_value;
	} req_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] mosi_byte;
		logic       select_low;
		logic [7:0] read_byte;
		logic [1:0] status;
		logic [2:0] data_response;
	} res_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [15:0] data;
	} cfg_t;

endpackage

// ----- src/smcbt_if.sv -----
// ----------------------------------------------------------------------------
// smcbt_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface smcbt_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- src/spi_mode_card_block_transfer.sv -----
// ----------------------------------------------------------------------------
// spi_mode_card_block_transfer
// Byte sequencer for SD/MMC single-block reads and writes in SPI mode.
// ----------------------------------------------------------------------------
// Usage: in_* carries events (start, card byte, host write byte); out_*
// carries results (exchange, read byte, write-byte request, done). cfg_*
// writes the poll and token limits; write only while idle.
// Timing: a request is registered in the front stage, then processed by
// the sequencer combinationally and its results registered in the output
// queue. One request per cycle is sustained while out_ready is high;
// a read data byte gives two results and fills the two-entry output
// queue, so the next request enters as the second result leaves.
// Reset clears the sequence state to idle, empties both stages and loads
// the default limits. When the receiver stalls, the output queue fills,
// the sequencer holds, and the front register holds one more request
// before in_ready falls.
// ----------------------------------------------------------------------------
module spi_mode_card_block_transfer #(
	parameter int BLOCK_BYTES      = 512,
	parameter int READY_FILL_BYTES = 10
) (
	input  logic  clk,
	input  logic  arst_n,
	smcbt_if.sink   in_ch,
	smcbt_if.sink   cfg,
	smcbt_if.source out_ch
);
	logic            q_valid, q_ready;
	smcbt_pkg::req_t q_data;

	smcbt_front u_front (
		.clk, .arst_n, .in_ch, .q_valid, .q_data, .q_ready
	);

	smcbt_back #(
		.BLOCK_BYTES(BLOCK_BYTES), .READY_FILL_BYTES(READY_FILL_BYTES)
	) u_back (
		.clk, .arst_n, .q_valid, .q_data, .q_ready, .cfg, .out_ch
	);
endmodule

// ----- src/smcbt_front.sv -----
// ----------------------------------------------------------------------------
// smcbt_front
// Input stage: registers requests, drops kinds that can never act.
// ----------------------------------------------------------------------------
module smcbt_front (
	input  logic                clk,
	input  logic                arst_n,
	smcbt_if.sink               in_ch,
	output logic                q_valid,
	output smcbt_pkg::req_t     q_data,
	input  logic                q_ready
);
	logic            v_q;
	smcbt_pkg::req_t d_q;

	assign in_ch.ready = !v_q || q_ready;
	assign q_valid     = v_q;
	assign q_data      = d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ch.ready) begin
			v_q <= in_ch.valid && (in_ch.data.kind != smcbt_pkg::KIND_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			d_q <= in_ch.data;
		end
	end
endmodule

// ----- src/smcbt_back.sv -----
// ----------------------------------------------------------------------------
// smcbt_back
// Transfer sequencer: one request per cycle while the output queue has
// room, up to two results into a two-entry output queue.
// ----------------------------------------------------------------------------
module smcbt_back #(
	parameter int BLOCK_BYTES      = 512,
	parameter int READY_FILL_BYTES = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  smcbt_pkg::req_t q_data,
	output logic            q_ready,
	smcbt_if.sink           cfg,
	smcbt_if.source         out_ch
);
	// byte counter covers the block, the fill run and the command bytes
	localparam int CW = 10;

	smcbt_pkg::phase_t ph_q, ph_n;
	logic        opw_q, opw_n;
	logic [31:0] addr_q, addr_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [15:0] poll_q, poll_n;
	logic [2:0]  resp_q, resp_n;
	logic [15:0] rlim_q, wlim_q, tlim_q;

	smcbt_pkg::res_t buf_q [2];
	logic [1:0]      cnt_o_q;
	smcbt_pkg::res_t r0, r1;
	logic [1:0]      nres;
	logic            go, pop;
	logic [15:0]     lim, poll_inc;
	logic [2:0]      rc;

	assign cfg.ready = 1'b1;
	assign q_ready   = (cnt_o_q == 2'd0) || (cnt_o_q == 2'd1 && pop);
	assign go        = q_valid && q_ready;
	assign out_ch.valid = cnt_o_q != 2'd0;
	assign out_ch.data  = buf_q[0];
	assign pop       = out_ch.valid && out_ch.ready;
	assign lim       = opw_q ? wlim_q : rlim_q;
	assign poll_inc  = (poll_q != 16'hFFFF) ? poll_q + 16'd1 : poll_q;
	assign rc        = 3'((q_data.byte_value & 8'h0F) >> 1);

	function automatic smcbt_pkg::res_t mk(smcbt_pkg::action_t a, logic [7:0] m,
		logic s, logic [7:0] rd, smcbt_pkg::status_t st, logic [2:0] dr);
		smcbt_pkg::res_t r;
		r.action = a; r.mosi_byte = m; r.select_low = s;
		r.read_byte = rd; r.status = st; r.data_response = dr;
		return r;
	endfunction

	function automatic logic [7:0] cmd_byte(logic [CW-1:0] i, logic w, logic [31:0] a);
		unique case (i)
			CW'(0): cmd_byte = smcbt_pkg::CMD_BASE
				+ (w ? smcbt_pkg::CMD_WRITE : smcbt_pkg::CMD_READ);
			CW'(1): cmd_byte = a[31:24];
			CW'(2): cmd_byte = a[23:16];
			CW'(3): cmd_byte = a[15:8];
			CW'(4): cmd_byte = a[7:0];
			default: cmd_byte = smcbt_pkg::CMD_CRC;
		endcase
	endfunction

	always_comb begin
		smcbt_pkg::res_t x;
		x = mk(smcbt_pkg::ACT_XCHG, smcbt_pkg::BYTE_FF, 1'b1, 8'd0, smcbt_pkg::ST_OK, 3'd0);
		ph_n = ph_q; opw_n = opw_q; addr_n = addr_q; cnt_n = cnt_q;
		poll_n = poll_q; resp_n = resp_q;
		r0 = x; r1 = x; nres = 2'd0;
		if (q_data.kind == smcbt_pkg::KIND_START) begin
			if (ph_q == smcbt_pkg::PH_IDLE) begin
				opw_n = q_data.is_write; addr_n = {q_data.sector, 9'd0};
				cnt_n = '0; poll_n = '0; resp_n = '0;
				ph_n = smcbt_pkg::PH_FILL; nres = 2'd1;
			end
		end else if (q_data.kind == smcbt_pkg::KIND_WDATA) begin
			if (ph_q == smcbt_pkg::PH_WNEED) begin
				ph_n = smcbt_pkg::PH_WDATA; r0.mosi_byte = q_data.byte_value; nres = 2'd1;
			end
		end else if (q_data.kind == smcbt_pkg::KIND_CARD) begin
			nres = 2'd1;
			unique case (ph_q)
				smcbt_pkg::PH_FILL: begin
					cnt_n = cnt_q + CW'(1);
					if (32'(cnt_n) >= READY_FILL_BYTES) ph_n = smcbt_pkg::PH_READY;
				end
				smcbt_pkg::PH_READY: begin
					cnt_n = '0;
					if (q_data.byte_value == 8'd0) ph_n = smcbt_pkg::PH_FILL;
					else begin
						ph_n = smcbt_pkg::PH_CMD;
						r0.mosi_byte = cmd_byte('0, opw_q, addr_q);
					end
				end
				smcbt_pkg::PH_CMD: begin
					cnt_n = cnt_q + CW'(1);
					if (cnt_n < CW'(6)) r0.mosi_byte = cmd_byte(cnt_n, opw_q, addr_q);
					else begin
						ph_n = smcbt_pkg::PH_R1; poll_n = '0;
					end
				end
				smcbt_pkg::PH_R1: begin
					poll_n = poll_inc;
					if (q_data.byte_value[7] && poll_inc < lim) begin
					end else if (opw_q) begin
						ph_n = smcbt_pkg::PH_WTOKEN; r0.mosi_byte = smcbt_pkg::TOKEN_START;
					end else begin
						ph_n = smcbt_pkg::PH_TOKEN; poll_n = '0;
					end
				end
				smcbt_pkg::PH_TOKEN: begin
					if (q_data.byte_value == smcbt_pkg::TOKEN_START) begin
						ph_n = smcbt_pkg::PH_RDATA; cnt_n = '0;
					end else begin
						poll_n = poll_inc;
						if (poll_inc >= tlim_q) begin
							ph_n = smcbt_pkg::PH_IDLE;
							r0 = mk(smcbt_pkg::ACT_DONE, 8'd0, 1'b0, 8'd0,
								smcbt_pkg::ST_TIMEOUT, 3'd0);
						end
					end
				end
				smcbt_pkg::PH_RDATA: begin
					r0 = mk(smcbt_pkg::ACT_RDATA, 8'd0, 1'b1, q_data.byte_value,
						smcbt_pkg::ST_OK, 3'd0);
					nres = 2'd2;
					if (32'(cnt_q) >= BLOCK_BYTES - 1) begin
						ph_n = smcbt_pkg::PH_RCRC; cnt_n = '0;
					end else cnt_n = cnt_q + CW'(1);
				end
				smcbt_pkg::PH_RCRC, smcbt_pkg::PH_WCRC: begin
					if (cnt_q == '0) cnt_n = CW'(1);
					else if (ph_q == smcbt_pkg::PH_RCRC) begin
						ph_n = smcbt_pkg::PH_TRAIL; r0.select_low = 1'b0;
					end else ph_n = smcbt_pkg::PH_WRESP;
				end
				smcbt_pkg::PH_TRAIL: begin
					ph_n = smcbt_pkg::PH_IDLE;
					r0 = mk(smcbt_pkg::ACT_DONE, 8'd0, 1'b0, 8'd0, smcbt_pkg::ST_OK,
						opw_q ? resp_q : 3'd0);
				end
				smcbt_pkg::PH_WTOKEN: begin
					ph_n = smcbt_pkg::PH_WNEED; cnt_n = '0;
					r0 = mk(smcbt_pkg::ACT_WNEED, 8'd0, 1'b1, 8'd0, smcbt_pkg::ST_OK, 3'd0);
				end
				smcbt_pkg::PH_WDATA: begin
					if (32'(cnt_q) >= BLOCK_BYTES - 1) begin
						ph_n = smcbt_pkg::PH_WCRC; cnt_n = '0;
					end else begin
						cnt_n = cnt_q + CW'(1); ph_n = smcbt_pkg::PH_WNEED;
						r0 = mk(smcbt_pkg::ACT_WNEED, 8'd0, 1'b1, 8'd0,
							smcbt_pkg::ST_OK, 3'd0);
					end
				end
				smcbt_pkg::PH_WRESP: begin
					resp_n = rc;
					if (rc != smcbt_pkg::RESP_OK) begin
						ph_n = smcbt_pkg::PH_IDLE;
						r0 = mk(smcbt_pkg::ACT_DONE, 8'd0, 1'b0, 8'd0,
							smcbt_pkg::ST_REJECT, rc);
					end else begin
						ph_n = smcbt_pkg::PH_TRAIL; r0.select_low = 1'b0;
					end
				end
				default: nres = 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= smcbt_pkg::PH_IDLE; opw_q <= 1'b0; addr_q <= '0; cnt_q <= '0;
			poll_q <= '0; resp_q <= '0; cnt_o_q <= '0;
			rlim_q <= smcbt_pkg::READ_POLL_RST;
			wlim_q <= smcbt_pkg::WRITE_POLL_RST;
			tlim_q <= smcbt_pkg::TOKEN_WAIT_RST;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.data.index)
					smcbt_pkg::CFG_READ_POLL:  rlim_q <= cfg.data.data;
					smcbt_pkg::CFG_WRITE_POLL: wlim_q <= cfg.data.data;
					smcbt_pkg::CFG_TOKEN_WAIT: tlim_q <= cfg.data.data;
					default: ;
				endcase
			end
			if (go) begin
				ph_q <= ph_n; opw_q <= opw_n; addr_q <= addr_n; cnt_q <= cnt_n;
				poll_q <= poll_n; resp_q <= resp_n;
			end
			cnt_o_q <= cnt_o_q - {1'b0, pop} + (go ? nres : 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) buf_q[0] <= buf_q[1];
		if (go && nres != 2'd0) begin
			if (cnt_o_q == 2'd0 || (cnt_o_q == 2'd1 && pop)) begin
				buf_q[0] <= r0;
				buf_q[1] <= r1;
			end
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_o_q <= 2'd2)
		else $error("output queue overflow");
	a_go_room: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> (cnt_o_q == 2'd0 || pop))
		else $error("request taken without queue room");
	a_idle_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.action == smcbt_pkg::ACT_DONE)
		|-> !out_ch.data.select_low)
		else $error("done with chip select low");
endmodule
